// File: design/script_variable_alu_unit_defines.svh
// Assertion macros for the script variable ALU unit.
// Used by the top level only; expects clk and rst in scope.
`ifndef SCRIPT_VARIABLE_ALU_UNIT_DEFINES_SVH
`define SCRIPT_VARIABLE_ALU_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition must never hold outside reset
`define SVAU_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("svau: forbidden condition seen");

// Consequent must hold in the cycle after the antecedent
`define SVAU_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svau: expected follow-up missing");

`else

`define SVAU_NEVER(label, expr)
`define SVAU_NEXT(label, ante, cons)

`endif

`endif

// File: design/svau_pkg.sv
// Shared types and constants for the script variable ALU unit.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package svau_pkg;

  // Operation codes carried in the kind field
  typedef enum logic [2:0] {
    KIND_DIV  = 3'd0,
    KIND_REM  = 3'd1,
    KIND_AND  = 3'd2,
    KIND_OR   = 3'd3,
    KIND_XOR  = 3'd4,
    KIND_LOAD = 3'd5
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADIV,
    ST_READ,
    ST_EXEC,
    ST_DDIV
  } state_t;

  localparam int unsigned DATA_W    = 16;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = 5'd16;
  localparam logic [DIV_CNT_W-1:0] WRAP_STEPS = 5'd2;
  localparam logic [DATA_W-1:0] QUOT_BY_ZERO = 16'hFFFF;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;        // latch the incoming word
    logic addr_from_div; // take the wrapped address from the divider
    logic div_start;     // load and start the divider
    logic div_data;      // divider works on cell data, not the address
    logic mem_read;      // read the addressed cell
    logic clear;         // write zero at the clearing pointer and advance
    logic finish_alu;    // write back the logic, load or by-zero result
    logic finish_div;    // write back the quotient or remainder
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_addr_div; // store size is not a power of two
    logic clr_last;      // clearing pointer at the last entry
    logic div_done;      // divider idle
    logic kind_div;      // divide or remainder
    logic opnd_zero;     // operand is zero
  } status_t;

endpackage

`default_nettype wire

// File: design/script_variable_alu_unit.sv
// Top level of the script variable ALU unit.
// Depends on svau_pkg, svau_ctrl, svau_datapath and the defines header.
//
// Read-modify-write unit on a store of ROWS*CELLS_PER_ROW 16-bit cells.
// Each input word picks the cell row*CELLS_PER_ROW+cell_req (wrapped to the
// store size), combines it with the operand (divide, remainder, and, or,
// xor, load), writes it back and returns the new value with a
// divide-by-zero flag. One word is processed at a time. Logic and load
// words pass the read and execute states on their way from acceptance to
// the output register; divide and remainder with a non-zero operand also
// pass the 16-step restoring divider. When ROWS*CELLS_PER_ROW is not a
// power of two the address wrap is done by a two-step reciprocal
// multiplication ahead of the read for every word. After reset the store
// is cleared one cell per cycle, during which in_ready stays low. A finished
// word waits in the output register while the next word is accepted.
`default_nettype none

`include "script_variable_alu_unit_defines.svh"

module script_variable_alu_unit #(
  parameter int unsigned ROWS          = 256,
  parameter int unsigned CELLS_PER_ROW = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [7:0]  row,
  input  wire logic [7:0]  cell_req,
  input  wire logic [15:0] operand,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      new_value,
  output logic             divide_by_zero
);

  svau_pkg::cmd_t    cmd;
  svau_pkg::status_t status;

  // Sequencer
  svau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Store, divider and logic unit
  svau_datapath #(
    .ROWS          (ROWS),
    .CELLS_PER_ROW (CELLS_PER_ROW)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .kind           (kind),
    .row            (row),
    .cell_req       (cell_req),
    .operand        (operand),
    .new_value      (new_value),
    .divide_by_zero (divide_by_zero)
  );

  // No word taken while the store is being cleared
  `SVAU_NEVER(a_no_accept_in_clear, cmd.clear && in_ready)
  // Never overwrite a result that is still waiting
  `SVAU_NEVER(a_no_result_overrun, (cmd.finish_alu || cmd.finish_div) && out_valid && !out_ready)
  // Divider is only started when idle
  `SVAU_NEVER(a_div_start_idle, cmd.div_start && !status.div_done)
  // A finished word is presented next cycle
  `SVAU_NEXT(a_finish_shows, cmd.finish_alu || cmd.finish_div, out_valid)

endmodule

`default_nettype wire

// File: design/svau_ctrl.sv
// Controller state machine for the script variable ALU unit.
// Depends on svau_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none

module svau_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire svau_pkg::status_t status,
  output svau_pkg::cmd_t         cmd
);

  svau_pkg::state_t state, state_next;
  logic             out_valid_next;
  logic             out_free;

  // Output register can take a new word this cycle
  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      svau_pkg::ST_CLEAR: begin
        if (status.clr_last) state_next = svau_pkg::ST_IDLE;
      end
      svau_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.need_addr_div ? svau_pkg::ST_ADIV : svau_pkg::ST_READ;
        end
      end
      svau_pkg::ST_ADIV: begin
        if (status.div_done) state_next = svau_pkg::ST_READ;
      end
      svau_pkg::ST_READ: begin
        state_next = svau_pkg::ST_EXEC;
      end
      svau_pkg::ST_EXEC: begin
        if (status.kind_div && !status.opnd_zero) begin
          state_next = svau_pkg::ST_DDIV;
        end else if (out_free) begin
          state_next = svau_pkg::ST_IDLE;
        end
      end
      svau_pkg::ST_DDIV: begin
        if (status.div_done && out_free) state_next = svau_pkg::ST_IDLE;
      end
      default: state_next = svau_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      svau_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
      end
      svau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept    = 1'b1;
          cmd.div_start = status.need_addr_div;
        end
      end
      svau_pkg::ST_ADIV: begin
        cmd.addr_from_div = status.div_done;
      end
      svau_pkg::ST_READ: begin
        cmd.mem_read = 1'b1;
      end
      svau_pkg::ST_EXEC: begin
        if (status.kind_div && !status.opnd_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_data  = 1'b1;
        end else begin
          cmd.finish_alu = out_free;
        end
      end
      svau_pkg::ST_DDIV: begin
        cmd.finish_div = status.div_done && out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_next = cmd.finish_alu || cmd.finish_div || (out_valid && !out_ready);
  end

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= svau_pkg::ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// File: design/svau_datapath.sv
// Datapath of the script variable ALU unit: variable store, address
// wrap, restoring divider, logic unit and output word register.
// Depends on svau_pkg; controlled by svau_ctrl through cmd_t.
`default_nettype none

module svau_datapath #(
  parameter int unsigned ROWS          = 256,
  parameter int unsigned CELLS_PER_ROW = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire svau_pkg::cmd_t    cmd,
  output svau_pkg::status_t      status,
  input  wire logic [2:0]        kind,
  input  wire logic [7:0]        row,
  input  wire logic [7:0]        cell_req,
  input  wire logic [15:0]       operand,
  output logic      [15:0]       new_value,
  output logic                   divide_by_zero
);

  localparam int unsigned STORE_WORDS = ROWS * CELLS_PER_ROW;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
  localparam bit          ADDR_POW2   = ((STORE_WORDS & (STORE_WORDS - 1)) == 0);
  localparam logic [15:0] WORDS_DIV   = 16'(STORE_WORDS % 65536);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);
  localparam int unsigned WRAP_SHIFT  = 16 + ADDR_W;
  localparam logic [16:0] WRAP_RECIP  =
    17'(((64'd1 << WRAP_SHIFT) + 64'(STORE_WORDS) - 64'd1) / 64'(STORE_WORDS));

  logic [15:0]                     mem [STORE_WORDS];
  logic [2:0]                      item_kind;
  logic [15:0]                     item_operand;
  logic [ADDR_W-1:0]               addr;
  logic [ADDR_W-1:0]               clr_cnt;
  logic [15:0]                     rdata;
  logic [15:0]                     quo;
  logic [15:0]                     rem;
  logic [15:0]                     div_divisor;
  logic [svau_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic                            wrap_mode;
  logic [32:0]                     wrap_prod;
  logic [15:0]                     wrap_quo;
  logic [15:0]                     wrap_back;
  logic [15:0]                     sum;
  logic [16:0]                     shifted;
  logic [16:0]                     trial;
  logic [15:0]                     alu_value;
  logic                            alu_dz;
  logic [15:0]                     result;
  logic                            mem_we;
  logic [ADDR_W-1:0]               mem_waddr;
  logic [15:0]                     mem_wdata;

  // Linear cell address before wrapping
  assign sum = 16'(row) * 16'(CELLS_PER_ROW) + 16'(cell_req);

  // Status back to the controller
  assign status.need_addr_div = !ADDR_POW2;
  assign status.clr_last      = (clr_cnt == LAST_ADDR);
  assign status.div_done      = (div_cnt == '0);
  assign status.kind_div      = (svau_pkg::kind_t'(item_kind) == svau_pkg::KIND_DIV) ||
                                (svau_pkg::kind_t'(item_kind) == svau_pkg::KIND_REM);
  assign status.opnd_zero     = (item_operand == '0);

  // Hold the accepted word and its address
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind    <= kind;
      item_operand <= operand;
      addr         <= sum[ADDR_W-1:0];
    end else if (cmd.addr_from_div) begin
      addr <= rem[ADDR_W-1:0];
    end
  end

  // Clearing pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Restoring divider step: one quotient bit per cycle
  assign shifted = {rem, quo[15]};
  assign trial   = shifted - {1'b0, div_divisor};

  // Address wrap by reciprocal multiplication: quotient estimate, then remainder
  assign wrap_prod = 33'(quo) * 33'(WRAP_RECIP);
  assign wrap_quo  = 16'(wrap_prod >> WRAP_SHIFT);
  assign wrap_back = rem * WORDS_DIV;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= cmd.div_data ? svau_pkg::DIV_STEPS : svau_pkg::WRAP_STEPS;
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo       <= cmd.div_data ? rdata : sum;
      rem       <= '0;
      wrap_mode <= !cmd.div_data;
      if (cmd.div_data) begin
        div_divisor <= item_operand;
      end
    end else if (div_cnt != '0) begin
      if (wrap_mode) begin
        if (div_cnt == svau_pkg::WRAP_STEPS) begin
          rem <= wrap_quo;
        end else begin
          rem <= quo - wrap_back;
        end
      end else if (!trial[16]) begin
        rem <= trial[15:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= shifted[15:0];
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

  // Logic unit, load and the by-zero cases
  always_comb begin
    alu_value = rdata;
    alu_dz    = 1'b0;
    case (svau_pkg::kind_t'(item_kind))
      svau_pkg::KIND_DIV: begin
        alu_value = svau_pkg::QUOT_BY_ZERO;
        alu_dz    = 1'b1;
      end
      svau_pkg::KIND_REM: begin
        alu_value = rdata;
        alu_dz    = 1'b1;
      end
      svau_pkg::KIND_AND:  alu_value = rdata & item_operand;
      svau_pkg::KIND_OR:   alu_value = rdata | item_operand;
      svau_pkg::KIND_XOR:  alu_value = rdata ^ item_operand;
      svau_pkg::KIND_LOAD: alu_value = item_operand;
      default:             alu_value = rdata;
    endcase
  end

  // Pick the write-back value
  always_comb begin
    if (cmd.finish_div) begin
      result = (svau_pkg::kind_t'(item_kind) == svau_pkg::KIND_DIV) ? quo : rem;
    end else begin
      result = alu_value;
    end
  end

  assign mem_we    = cmd.clear || cmd.finish_alu || cmd.finish_div;
  assign mem_waddr = cmd.clear ? clr_cnt : addr;
  assign mem_wdata = cmd.clear ? '0 : result;

  // Variable store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.mem_read) begin
      rdata <= mem[addr];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.finish_alu || cmd.finish_div) begin
      new_value      <= result;
      divide_by_zero <= cmd.finish_alu && alu_dz;
    end
  end

endmodule

`default_nettype wire
